@@ hdl/aps_pkg.sv @@
// Package for the actuator position servo: codes, register map, reset values
// and the configuration struct shared by all modules. No dependencies.
package aps_pkg;

  localparam int unsigned POSITION_BITS_DEF = 18;
  localparam int unsigned TIMER_BITS_DEF    = 24;

  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_STEPS_PER_MM   = 3'd0,
    REG_DEADBAND       = 3'd1,
    REG_DEBOUNCE       = 3'd2,
    REG_TIMEOUT        = 3'd3,
    REG_HOMING_WINDOW  = 3'd4,
    REG_MAX_STEPS      = 3'd5,
    REG_DRIVE_SPEED    = 3'd6,
    REG_DEPTH_OFFSET   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_EDGE    = 2'd1,
    MODE_MEASURE = 2'd2,
    MODE_HOME    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_EXTEND  = 2'd1,
    DIR_RETRACT = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_REACHED       = 3'd1,
    EV_TIMEOUT       = 3'd2,
    EV_HOMED         = 3'd3,
    EV_DROPPED       = 3'd4,
    EV_OUT_OF_WINDOW = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    TGT_IDLE = 2'd0,
    TGT_MUL  = 2'd1,
    TGT_DIV  = 2'd2,
    TGT_DONE = 2'd3
  } tgt_state_e;

  typedef struct packed {
    logic [9:0]         steps_per_mm;
    logic [9:0]         deadband_steps;
    logic [7:0]         debounce_ticks;
    logic [23:0]        timeout_ticks;
    logic [23:0]        homing_window_ticks;
    logic [16:0]        max_steps;
    logic [9:0]         drive_speed;
    logic signed [23:0] depth_offset;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic busy;
    logic done;
  } tgt_stat_t;

  localparam logic [9:0]         RST_STEPS_PER_MM   = 10'd155;
  localparam logic [9:0]         RST_DEADBAND       = 10'd66;
  localparam logic [7:0]         RST_DEBOUNCE       = 8'd10;
  localparam logic [23:0]        RST_TIMEOUT        = 24'd2000000;
  localparam logic [23:0]        RST_HOMING_WINDOW  = 24'd50000;
  localparam logic [16:0]        RST_MAX_STEPS      = 17'd21800;
  localparam logic [9:0]         RST_DRIVE_SPEED    = 10'd1023;
  localparam logic signed [23:0] RST_DEPTH_OFFSET   = 24'sd0;

  localparam logic signed [24:0] WINDOW_HUNDREDTHS = 25'sd4000;
  localparam logic signed [23:0] HOME_HUNDREDTHS   = 24'sd5000;
  localparam logic signed [25:0] ADJ_MAX           = 26'sd8388607;
  localparam logic signed [25:0] ADJ_MIN           = -26'sd8388608;
  localparam logic [7:0]         EDGE_MAX          = 8'd255;

  // Reciprocal of 100 scaled by 2**31; exact for every 24-bit dividend.
  localparam logic [24:0]  RECIP_100   = 25'd21474837;
  localparam int unsigned  RECIP_SHIFT = 31;
  localparam logic [24:0]  HUNDRED     = 25'd100;

endpackage

@@ hdl/actuator_position_servo_top.sv @@
// Top level of the actuator position servo: input and result registers around
// aps_core, with aps_target and aps_cfg. Uses aps_pkg.
//
//   Channel  Handshake              Beat contents
//   input    in_valid_i/in_ready_o  mode_i, depth_value_i
//   result   out_valid_o/out_ready_i right_duty_o, left_duty_o,
//                                    position_count_o, busy_res_o, event_res_o
//   config   psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// An input beat waits in the input register, and its result is then registered
// in the result register; a depth measurement that starts a move holds the
// input register while the target unit multiplies and divides.
// Reset loads the register defaults, stops the drive, clears the count and
// sets the adjusted position to 50 mm. A stalled result keeps one further
// input beat in the input register; beyond that in_ready_o drops.
module actuator_position_servo_top #(
  parameter int unsigned POSITION_BITS = aps_pkg::POSITION_BITS_DEF,
  parameter int unsigned TIMER_BITS    = aps_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aps_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [aps_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [aps_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [23:0]                  depth_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [9:0]                          right_duty_o,
  output logic [9:0]                          left_duty_o,
  output logic signed [POSITION_BITS-1:0]     position_count_o,
  output logic                                busy_res_o,
  output logic [2:0]                          event_res_o
);
  import aps_pkg::*;

  cfg_t                     cfg;
  tgt_stat_t                tgt_stat;
  logic [POSITION_BITS-1:0] tgt_target;
  logic                     proceed, launch, out_free;
  logic signed [23:0]       adj;

  logic                     in_valid_q;
  logic [1:0]               mode_q;
  logic signed [23:0]       depth_q;

  logic [9:0]               right_d, left_d;
  logic [POSITION_BITS-1:0] pos_d;
  logic                     busy_d;
  event_e                   ev_d;

  logic                     out_valid_q;
  logic [9:0]               right_q, left_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic                     busy_q;
  logic [2:0]               ev_q;

  aps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aps_target #(
    .POSITION_BITS (POSITION_BITS)
  ) u_target (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (launch),
    .ack_i    (proceed),
    .adj_i    (adj),
    .cfg_i    (cfg),
    .stat_o   (tgt_stat),
    .target_o (tgt_target)
  );

  aps_core #(
    .POSITION_BITS (POSITION_BITS),
    .TIMER_BITS    (TIMER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .out_free_i   (out_free),
    .mode_i       (mode_e'(mode_q)),
    .depth_i      (depth_q),
    .cfg_i        (cfg),
    .tgt_stat_i   (tgt_stat),
    .tgt_target_i (tgt_target),
    .proceed_o    (proceed),
    .launch_o     (launch),
    .adj_o        (adj),
    .right_duty_o (right_d),
    .left_duty_o  (left_d),
    .position_o   (pos_d),
    .busy_o       (busy_d),
    .event_o      (ev_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (proceed) begin
        in_valid_q <= 1'b0;
      end
      if (proceed) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      depth_q <= depth_value_i;
    end
    if (proceed) begin
      right_q <= right_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      busy_q  <= busy_d;
      ev_q    <= ev_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign right_duty_o     = right_q;
  assign left_duty_o      = left_q;
  assign position_count_o = $signed(pos_q);
  assign busy_res_o       = busy_q;
  assign event_res_o      = ev_q;

  a_idle_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (right_duty_o == 10'd0 && left_duty_o == 10'd0))
    else $error("drive active while the servo reports idle");

  a_stop_events_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_REACHED || event_res_o == EV_TIMEOUT ||
     event_res_o == EV_HOMED)) |-> !busy_res_o)
    else $error("stop event reported while still busy");

  a_homed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_HOMED) |-> (position_count_o == '0))
    else $error("homing finished with a nonzero count");

  a_target_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_stat.busy |-> !in_ready_o)
    else $error("input taken while the target unit is working");

endmodule

@@ hdl/aps_cfg.sv @@
// Configuration register bank of the actuator position servo behind an
// APB-style port. Depends on aps_pkg.
module aps_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aps_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [aps_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [aps_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output aps_pkg::cfg_t                       cfg_o
);
  import aps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STEPS_PER_MM:  cfg_d.steps_per_mm        = pwdata[9:0];
        REG_DEADBAND:      cfg_d.deadband_steps      = pwdata[9:0];
        REG_DEBOUNCE:      cfg_d.debounce_ticks      = pwdata[7:0];
        REG_TIMEOUT:       cfg_d.timeout_ticks       = pwdata[23:0];
        REG_HOMING_WINDOW: cfg_d.homing_window_ticks = pwdata[23:0];
        REG_MAX_STEPS:     cfg_d.max_steps           = pwdata[16:0];
        REG_DRIVE_SPEED:   cfg_d.drive_speed         = pwdata[9:0];
        REG_DEPTH_OFFSET:  cfg_d.depth_offset        = $signed(pwdata[23:0]);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEPS_PER_MM:  prdata = {22'd0, cfg_q.steps_per_mm};
      REG_DEADBAND:      prdata = {22'd0, cfg_q.deadband_steps};
      REG_DEBOUNCE:      prdata = {24'd0, cfg_q.debounce_ticks};
      REG_TIMEOUT:       prdata = {8'd0, cfg_q.timeout_ticks};
      REG_HOMING_WINDOW: prdata = {8'd0, cfg_q.homing_window_ticks};
      REG_MAX_STEPS:     prdata = {15'd0, cfg_q.max_steps};
      REG_DRIVE_SPEED:   prdata = {22'd0, cfg_q.drive_speed};
      REG_DEPTH_OFFSET:  prdata = {{8{cfg_q.depth_offset[23]}}, cfg_q.depth_offset};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_mm        <= RST_STEPS_PER_MM;
      cfg_q.deadband_steps      <= RST_DEADBAND;
      cfg_q.debounce_ticks      <= RST_DEBOUNCE;
      cfg_q.timeout_ticks       <= RST_TIMEOUT;
      cfg_q.homing_window_ticks <= RST_HOMING_WINDOW;
      cfg_q.max_steps           <= RST_MAX_STEPS;
      cfg_q.drive_speed         <= RST_DRIVE_SPEED;
      cfg_q.depth_offset        <= RST_DEPTH_OFFSET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/aps_target.sv @@
// Target unit: converts the adjusted position to a saturated step target in
// two registered steps (multiply by steps_per_mm, divide by 100). Uses aps_pkg.
module aps_target #(
  parameter int unsigned POSITION_BITS = aps_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      ack_i,
  input  logic signed [23:0]        adj_i,
  input  aps_pkg::cfg_t             cfg_i,
  output aps_pkg::tgt_stat_t        stat_o,
  output logic [POSITION_BITS-1:0]  target_o
);
  import aps_pkg::*;

  localparam int unsigned LW = (POSITION_BITS > 17) ? POSITION_BITS : 17;
  localparam logic [LW-1:0] POS_MAX = LW'({1'b0, {(POSITION_BITS-1){1'b1}}});

  tgt_state_e  state_q, state_d;
  logic [32:0] prod_q, prod_d;
  logic [16:0] quot_q, quot_d;
  logic        over_q, over_d;
  logic [LW-1:0] max_w, lim_w, tgt_w;
  logic [17:0] lim_p1;
  logic [24:0] lim100;
  logic [48:0] recip_prod;

  assign max_w  = LW'(cfg_i.max_steps);
  assign lim_w  = (max_w > POS_MAX) ? POS_MAX : max_w;
  assign lim_p1 = 18'(lim_w[16:0]) + 18'd1;
  assign lim100 = 25'(lim_p1) * HUNDRED;

  assign recip_prod = 49'(prod_q[23:0]) * 49'(RECIP_100);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TGT_IDLE: if (start_i) state_d = TGT_MUL;
      TGT_MUL:  state_d = TGT_DIV;
      TGT_DIV:  state_d = TGT_DONE;
      TGT_DONE: if (ack_i) state_d = TGT_IDLE;
      default:  state_d = TGT_IDLE;
    endcase
  end

  always_comb begin
    prod_d = prod_q;
    quot_d = quot_q;
    over_d = over_q;
    unique case (state_q)
      TGT_MUL: begin
        prod_d = (adj_i > 24'sd0) ? (33'(adj_i[22:0]) * 33'(cfg_i.steps_per_mm)) : '0;
      end
      TGT_DIV: begin
        quot_d = recip_prod[RECIP_SHIFT+16:RECIP_SHIFT];
        over_d = (prod_q >= 33'(lim100));
      end
      default: begin
        prod_d = prod_q;
      end
    endcase
  end

  always_comb begin
    stat_o.idle = (state_q == TGT_IDLE);
    stat_o.busy = (state_q == TGT_MUL) || (state_q == TGT_DIV);
    stat_o.done = (state_q == TGT_DONE);
  end

  assign tgt_w    = over_q ? lim_w : LW'(quot_q);
  assign target_o = tgt_w[POSITION_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TGT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quot_q <= quot_d;
    over_q <= over_d;
  end

endmodule

@@ hdl/aps_core.sv @@
// Servo state and single-pass update: time base, debounced edge count, depth
// handling, homing and the bang-bang controller. Uses aps_pkg.
module aps_core #(
  parameter int unsigned POSITION_BITS = aps_pkg::POSITION_BITS_DEF,
  parameter int unsigned TIMER_BITS    = aps_pkg::TIMER_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  logic                      out_free_i,
  input  aps_pkg::mode_e            mode_i,
  input  logic signed [23:0]        depth_i,
  input  aps_pkg::cfg_t             cfg_i,
  input  aps_pkg::tgt_stat_t        tgt_stat_i,
  input  logic [POSITION_BITS-1:0]  tgt_target_i,
  output logic                      proceed_o,
  output logic                      launch_o,
  output logic signed [23:0]        adj_o,
  output logic [9:0]                right_duty_o,
  output logic [9:0]                left_duty_o,
  output logic [POSITION_BITS-1:0]  position_o,
  output logic                      busy_o,
  output aps_pkg::event_e           event_o
);
  import aps_pkg::*;

  localparam int unsigned CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;
  localparam logic signed [POSITION_BITS-1:0] POS_MAX =
    $signed({1'b0, {(POSITION_BITS-1){1'b1}}});
  localparam logic signed [POSITION_BITS-1:0] POS_MIN =
    $signed({1'b1, {(POSITION_BITS-1){1'b0}}});
  localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;

  logic signed [POSITION_BITS-1:0] cnt_q, cnt_d, tgt_q, tgt_d, snap_q, snap_d;
  dir_e                            dir_q, dir_d;
  logic                            moving_q, moving_d, homing_q, homing_d;
  logic [TIMER_BITS-1:0]           move_el_q, move_el_d, win_el_q, win_el_d, win_next;
  logic [7:0]                      since_q, since_d;
  logic signed [23:0]              adj_q, adj_d;
  event_e                          ev;

  logic signed [24:0]              err;
  logic signed [25:0]              adj_sum;
  logic                            in_win, busy_now, meas_start;
  logic signed [POSITION_BITS:0]   dif;
  logic [POSITION_BITS:0]          mag;

  assign err      = {depth_i[23], depth_i} - {cfg_i.depth_offset[23], cfg_i.depth_offset};
  assign in_win   = !((err > WINDOW_HUNDREDTHS) || (err < -WINDOW_HUNDREDTHS));
  assign busy_now = moving_q | homing_q;
  assign meas_start = (mode_i == MODE_MEASURE) && !busy_now && in_win;
  assign adj_sum  = {{2{adj_q[23]}}, adj_q} - {err[24], err};
  assign win_next = (win_el_q != TMR_MAX) ? win_el_q + 1'b1 : win_el_q;

  assign proceed_o = item_valid_i && out_free_i && (!meas_start || tgt_stat_i.done);
  assign launch_o  = item_valid_i && meas_start && tgt_stat_i.idle;
  assign adj_o     = adj_q;

  always_comb begin
    if (adj_sum > ADJ_MAX) begin
      adj_d = ADJ_MAX[23:0];
    end else if (adj_sum < ADJ_MIN) begin
      adj_d = ADJ_MIN[23:0];
    end else begin
      adj_d = adj_sum[23:0];
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    tgt_d     = tgt_q;
    snap_d    = snap_q;
    dir_d     = dir_q;
    moving_d  = moving_q;
    homing_d  = homing_q;
    move_el_d = move_el_q;
    win_el_d  = win_el_q;
    since_d   = since_q;
    ev        = EV_NONE;
    dif       = '0;
    mag       = '0;

    unique case (mode_i)
      MODE_TICK: begin
        if (since_q != EDGE_MAX) since_d = since_q + 8'd1;
        if (moving_q && (move_el_q != TMR_MAX)) move_el_d = move_el_q + 1'b1;
        if (homing_q) begin
          if (CW'(win_next) >= CW'(cfg_i.homing_window_ticks)) begin
            win_el_d = '0;
            if (cnt_q == snap_q) begin
              cnt_d    = '0;
              homing_d = 1'b0;
              dir_d    = DIR_STOP;
              ev       = EV_HOMED;
            end else begin
              snap_d = cnt_q;
            end
          end else begin
            win_el_d = win_next;
          end
        end
      end
      MODE_EDGE: begin
        if ((since_q == EDGE_MAX) || (since_q > cfg_i.debounce_ticks)) begin
          since_d = '0;
          if ((dir_q == DIR_EXTEND) && (cnt_q != POS_MAX)) begin
            cnt_d = cnt_q + 1'b1;
          end else if ((dir_q == DIR_RETRACT) && (cnt_q != POS_MIN)) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      MODE_MEASURE: begin
        if (busy_now) begin
          ev = EV_DROPPED;
        end else if (!in_win) begin
          ev = EV_OUT_OF_WINDOW;
        end else begin
          tgt_d     = $signed(tgt_target_i);
          moving_d  = 1'b1;
          move_el_d = '0;
        end
      end
      MODE_HOME: begin
        homing_d = 1'b1;
        moving_d = 1'b0;
        dir_d    = DIR_RETRACT;
        win_el_d = '0;
        snap_d   = cnt_q;
      end
      default: begin
        ev = EV_NONE;
      end
    endcase

    if (moving_d) begin
      dif = {cnt_d[POSITION_BITS-1], cnt_d} - {tgt_d[POSITION_BITS-1], tgt_d};
      mag = dif[POSITION_BITS] ? $unsigned(-dif) : $unsigned(dif);
      if (mag <= (POSITION_BITS+1)'(cfg_i.deadband_steps)) begin
        moving_d = 1'b0;
        dir_d    = DIR_STOP;
        ev       = EV_REACHED;
      end else begin
        dir_d = (tgt_d < cnt_d) ? DIR_RETRACT : DIR_EXTEND;
        if (CW'(move_el_d) > CW'(cfg_i.timeout_ticks)) begin
          moving_d = 1'b0;
          dir_d    = DIR_STOP;
          ev       = EV_TIMEOUT;
        end
      end
    end
  end

  assign right_duty_o = (dir_d == DIR_EXTEND)  ? cfg_i.drive_speed : 10'd0;
  assign left_duty_o  = (dir_d == DIR_RETRACT) ? cfg_i.drive_speed : 10'd0;
  assign position_o   = cnt_d;
  assign busy_o       = moving_d | homing_d;
  assign event_o      = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      tgt_q     <= '0;
      snap_q    <= '0;
      dir_q     <= DIR_STOP;
      moving_q  <= 1'b0;
      homing_q  <= 1'b0;
      move_el_q <= '0;
      win_el_q  <= '0;
      since_q   <= EDGE_MAX;
      adj_q     <= HOME_HUNDREDTHS;
    end else begin
      if (proceed_o) begin
        cnt_q     <= cnt_d;
        tgt_q     <= tgt_d;
        snap_q    <= snap_d;
        dir_q     <= dir_d;
        moving_q  <= moving_d;
        homing_q  <= homing_d;
        move_el_q <= move_el_d;
        win_el_q  <= win_el_d;
        since_q   <= since_d;
      end
      if (launch_o) begin
        adj_q <= adj_d;
      end
    end
  end

endmodule
